/* design/multilevel_feedback_queue_scheduler_core_assert.svh */
// ============================================================================
// Assertion macros for the multilevel feedback queue scheduler
// Implication checks sampled on i_clk and disabled while i_rst_n is low.
// ============================================================================
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication
`define MFQS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MFQS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/mfqs_pkg.sv */
// ============================================================================
// mfqs_pkg
// Shared types, codes and constants of the multilevel feedback queue scheduler.
// ============================================================================
package mfqs_pkg;

    // Port field widths
    localparam int SLOT_IW  = 6;
    localparam int LEVEL_OW = 2;
    localparam int TICKS_OW = 32;
    localparam int LIMIT_W  = 16;

    // Configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_LIMIT1 = 2'd0;
    localparam logic [1:0] REG_LIMIT2 = 2'd1;
    localparam logic [1:0] REG_LIMIT3 = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT1_RST = 16'd32;
    localparam logic [LIMIT_W-1:0] LIMIT2_RST = 16'd16;
    localparam logic [LIMIT_W-1:0] LIMIT3_RST = 16'd8;

    // Parameter defaults
    localparam int DEF_NUM_SLOTS  = 64;
    localparam int DEF_NUM_LEVELS = 4;
    localparam int DEF_TICK_WIDTH = 32;

    typedef enum logic [1:0] {
        ACT_ADMIT     = 2'd0,
        ACT_SET_READY = 2'd1,
        ACT_RELEASE   = 2'd2,
        ACT_TICK      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_IDLE = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_UNL_RD,
        S_UNL_HEAD,
        S_UNL_WALK,
        S_SCAN_LVL,
        S_SCAN,
        S_CHARGE,
        S_APPEND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [LIMIT_W-1:0] lim1;
        logic [LIMIT_W-1:0] lim2;
        logic [LIMIT_W-1:0] lim3;
    } t_limits;

    typedef struct packed {
        logic                granted;
        logic [SLOT_IW-1:0]  slot;
        logic [LEVEL_OW-1:0] level;
        logic                demoted;
        logic [TICKS_OW-1:0] ticks;
        t_status             status;
    } t_result;

endpackage

/* design/mfqs_cfg_regs.sv */
// ============================================================================
// mfqs_cfg_regs
// APB-style register file holding the per-level slice limits.
// ============================================================================
module mfqs_cfg_regs
    import mfqs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_limits           o_limits
);

    t_limits    r_limits;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready   = 1'b1;
    assign w_wr     = psel & penable & pwrite;
    assign w_idx    = paddr[3:2];
    assign o_limits = r_limits;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.lim1 <= LIMIT1_RST;
            r_limits.lim2 <= LIMIT2_RST;
            r_limits.lim3 <= LIMIT3_RST;
        end else if (w_wr) begin
            if (w_idx == REG_LIMIT1) r_limits.lim1 <= pwdata[LIMIT_W-1:0];
            if (w_idx == REG_LIMIT2) r_limits.lim2 <= pwdata[LIMIT_W-1:0];
            if (w_idx == REG_LIMIT3) r_limits.lim3 <= pwdata[LIMIT_W-1:0];
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_LIMIT1: prdata = CFG_DW'(r_limits.lim1);
            REG_LIMIT2: prdata = CFG_DW'(r_limits.lim2);
            REG_LIMIT3: prdata = CFG_DW'(r_limits.lim3);
            default:    prdata = '0;
        endcase
    end

endmodule

/* design/mfqs_tick_alu.sv */
// ============================================================================
// mfqs_tick_alu
// Saturating tick charge and slice-limit compare.
// ============================================================================
module mfqs_tick_alu
    import mfqs_pkg::*;
#(
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
    input  logic [TICK_WIDTH-1:0] i_count,
    input  logic [LIMIT_W-1:0]    i_limit,
    input  logic                  i_level_nonzero,
    output logic [TICK_WIDTH-1:0] o_count,
    output logic                  o_demote
);

    localparam int CW = (TICK_WIDTH > LIMIT_W) ? TICK_WIDTH : LIMIT_W;

    // count sticks at all ones
    assign o_count  = (&i_count) ? i_count : i_count + TICK_WIDTH'(1);
    assign o_demote = i_level_nonzero && (CW'(o_count) >= CW'(i_limit));

endmodule

/* design/mfqs_engine.sv */
// ============================================================================
// mfqs_engine
// Queue sequencer: slot table, linked FIFOs per level, tick counters.
// ============================================================================
module mfqs_engine
    import mfqs_pkg::*;
#(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int NUM_LEVELS = DEF_NUM_LEVELS,
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_limits            i_limits,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [SLOT_IW-1:0] i_slot_index,
    input  logic               i_ready_req,
    output logic               o_done,
    input  logic               i_take,
    output t_result            o_result
);

`include "multilevel_feedback_queue_scheduler_core_assert.svh"

    localparam int SW          = $clog2(NUM_SLOTS);
    localparam int LW          = $clog2(NUM_LEVELS);
    localparam int SLOT_DEPTH  = 1 << SW;
    localparam int LEVEL_DEPTH = 1 << LW;
    localparam int TAW         = SW + LW;
    localparam int TICK_DEPTH  = 1 << TAW;
    localparam logic [LW-1:0] TOP = LW'(NUM_LEVELS - 1);

    // control state
    t_state                  r_state, n_state;
    logic [SLOT_DEPTH-1:0]   r_in_use, n_in_use;
    logic [SLOT_DEPTH-1:0]   r_ready, n_ready;
    logic [LEVEL_DEPTH-1:0]  r_nonempty, n_nonempty;
    logic [SW-1:0]           r_head [LEVEL_DEPTH];
    logic [SW-1:0]           n_head [LEVEL_DEPTH];
    logic [SW-1:0]           r_tail [LEVEL_DEPTH];
    logic [SW-1:0]           n_tail [LEVEL_DEPTH];

    // item and work registers
    t_action                 r_action, n_action;
    logic [SW-1:0]           r_slot, n_slot;
    logic                    r_slot_ok, n_slot_ok;
    logic                    r_rdy_req, n_rdy_req;
    t_status                 r_status, n_status;
    logic                    r_granted, n_granted;
    logic                    r_dem, n_dem;
    logic [TICK_WIDTH-1:0]   r_ticks, n_ticks;
    logic [LW-1:0]           r_lvl, n_lvl;
    logic [SW-1:0]           r_cur, n_cur;
    logic                    r_use_link, n_use_link;
    logic [SW-1:0]           r_unl, n_unl;
    logic [SW-1:0]           r_next_s, n_next_s;
    logic [SW-1:0]           r_prev, n_prev;
    logic [LW-1:0]           r_clr, n_clr;

    // memories
    logic [SW-1:0]           r_link_mem [SLOT_DEPTH];
    logic [LW-1:0]           r_level_mem [SLOT_DEPTH];
    logic [TICK_WIDTH-1:0]   r_tick_mem [TICK_DEPTH];
    logic [SW-1:0]           r_link_rdata;
    logic [LW-1:0]           r_ulvl;
    logic [TICK_WIDTH-1:0]   r_tick_rdata;

    logic                    w_link_we;
    logic [SW-1:0]           w_link_waddr, w_link_wdata, w_link_raddr;
    logic                    w_lvl_we, w_lvl_re;
    logic [SW-1:0]           w_lvl_waddr, w_lvl_raddr;
    logic [LW-1:0]           w_lvl_wdata;
    logic                    w_tick_we, w_tick_re;
    logic [TAW-1:0]          w_tick_waddr, w_tick_raddr;
    logic [TICK_WIDTH-1:0]   w_tick_wdata;

    logic                    w_in_ok;
    logic [SW-1:0]           w_cur;
    logic [LW-1:0]           w_lvl_down;
    logic                    w_unl_done;
    logic [LIMIT_W-1:0]      w_limit;
    logic [TICK_WIDTH-1:0]   w_alu_count;
    logic                    w_alu_demote;

    assign w_in_ok    = int'(i_slot_index) < NUM_SLOTS;
    assign w_cur      = r_use_link ? r_link_rdata : r_cur;
    assign w_lvl_down = r_lvl - LW'(1);

    // slice limit of the level being charged
    always_comb begin
        if (int'(r_lvl) >= 3)      w_limit = i_limits.lim3;
        else if (int'(r_lvl) == 2) w_limit = i_limits.lim2;
        else                       w_limit = i_limits.lim1;
    end

    mfqs_tick_alu #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_tick_alu (
        .i_count         (r_tick_rdata),
        .i_limit         (w_limit),
        .i_level_nonzero (r_lvl != '0),
        .o_count         (w_alu_count),
        .o_demote        (w_alu_demote)
    );

    // sequencer: next state, queue updates, memory strobes
    always_comb begin
        n_state    = r_state;
        n_in_use   = r_in_use;
        n_ready    = r_ready;
        n_nonempty = r_nonempty;
        n_head     = r_head;
        n_tail     = r_tail;
        n_action   = r_action;
        n_slot     = r_slot;
        n_slot_ok  = r_slot_ok;
        n_rdy_req  = r_rdy_req;
        n_status   = r_status;
        n_granted  = r_granted;
        n_dem      = r_dem;
        n_ticks    = r_ticks;
        n_lvl      = r_lvl;
        n_cur      = r_cur;
        n_use_link = r_use_link;
        n_unl      = r_unl;
        n_next_s   = r_next_s;
        n_prev     = r_prev;
        n_clr      = r_clr;

        w_link_we    = 1'b0;
        w_link_waddr = '0;
        w_link_wdata = '0;
        w_link_raddr = r_cur;
        w_lvl_we     = 1'b0;
        w_lvl_re     = 1'b0;
        w_lvl_waddr  = '0;
        w_lvl_wdata  = '0;
        w_lvl_raddr  = r_unl;
        w_tick_we    = 1'b0;
        w_tick_re    = 1'b0;
        w_tick_waddr = '0;
        w_tick_wdata = '0;
        w_tick_raddr = '0;
        w_unl_done   = 1'b0;
        o_ready      = 1'b0;
        o_done       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_action  = t_action'(i_action);
                    n_slot    = SW'(i_slot_index);
                    n_slot_ok = w_in_ok;
                    n_rdy_req = i_ready_req;
                    n_state   = S_DECODE;
                end
            end

            S_DECODE: begin
                n_granted = 1'b0;
                n_dem     = 1'b0;
                n_status  = ST_OK;
                unique case (r_action)
                    ACT_ADMIT: begin
                        if (!r_slot_ok || r_in_use[r_slot]) begin
                            n_status = ST_BAD;
                            n_state  = S_DONE;
                        end else begin
                            n_in_use[r_slot] = 1'b1;
                            n_ready[r_slot]  = 1'b0;
                            w_lvl_we         = 1'b1;
                            w_lvl_waddr      = r_slot;
                            w_lvl_wdata      = TOP;
                            // append at the tail of the top queue
                            if (r_nonempty[TOP]) begin
                                w_link_we    = 1'b1;
                                w_link_waddr = r_tail[TOP];
                                w_link_wdata = r_slot;
                            end else begin
                                n_head[TOP]     = r_slot;
                                n_nonempty[TOP] = 1'b1;
                            end
                            n_tail[TOP] = r_slot;
                            n_clr       = '0;
                            n_state     = S_CLEAR;
                        end
                    end
                    ACT_SET_READY: begin
                        if (r_slot_ok && r_in_use[r_slot]) n_ready[r_slot] = r_rdy_req;
                        else                               n_status = ST_BAD;
                        n_state = S_DONE;
                    end
                    ACT_RELEASE: begin
                        if (r_slot_ok && r_in_use[r_slot]) begin
                            n_unl   = r_slot;
                            n_state = S_UNL_RD;
                        end else begin
                            n_status = ST_BAD;
                            n_state  = S_DONE;
                        end
                    end
                    ACT_TICK: begin
                        n_lvl   = TOP;
                        n_state = S_SCAN_LVL;
                    end
                    default: n_state = S_DONE;
                endcase
            end

            // zero the slot's tick count at every level, one a cycle
            S_CLEAR: begin
                w_tick_we    = 1'b1;
                w_tick_waddr = {r_slot, r_clr};
                w_tick_wdata = '0;
                if (r_clr == LW'(NUM_LEVELS - 1)) n_state = S_DONE;
                else                              n_clr = r_clr + LW'(1);
            end

            // fetch level and successor of the slot to unlink
            S_UNL_RD: begin
                w_lvl_re     = 1'b1;
                w_lvl_raddr  = r_unl;
                w_link_raddr = r_unl;
                n_state      = S_UNL_HEAD;
            end

            S_UNL_HEAD: begin
                n_next_s = r_link_rdata;
                if (!r_nonempty[r_ulvl]) begin
                    w_unl_done = 1'b1;
                end else if (r_head[r_ulvl] == r_unl) begin
                    if (r_tail[r_ulvl] == r_unl) n_nonempty[r_ulvl] = 1'b0;
                    else                         n_head[r_ulvl] = r_link_rdata;
                    w_unl_done = 1'b1;
                end else if (r_head[r_ulvl] == r_tail[r_ulvl]) begin
                    w_unl_done = 1'b1;
                end else begin
                    w_link_raddr = r_head[r_ulvl];
                    n_prev       = r_head[r_ulvl];
                    n_state      = S_UNL_WALK;
                end
            end

            // one link per cycle until the predecessor or the queue tail is found
            S_UNL_WALK: begin
                if (r_link_rdata == r_unl) begin
                    w_link_we    = 1'b1;
                    w_link_waddr = r_prev;
                    w_link_wdata = r_next_s;
                    if (r_tail[r_ulvl] == r_unl) n_tail[r_ulvl] = r_prev;
                    w_unl_done = 1'b1;
                end else if (r_link_rdata == r_tail[r_ulvl]) begin
                    w_unl_done = 1'b1;
                end else begin
                    w_link_raddr = r_link_rdata;
                    n_prev       = r_link_rdata;
                end
            end

            S_SCAN_LVL: begin
                if (r_nonempty[r_lvl]) begin
                    n_cur      = r_head[r_lvl];
                    n_use_link = 1'b0;
                    n_state    = S_SCAN;
                end else if (r_lvl == '0) begin
                    n_status = ST_IDLE;
                    n_state  = S_DONE;
                end else begin
                    n_lvl = w_lvl_down;
                end
            end

            // walk one queue entry per cycle
            S_SCAN: begin
                n_cur = w_cur;
                if (r_ready[w_cur]) begin
                    n_use_link   = 1'b0;
                    w_tick_re    = 1'b1;
                    w_tick_raddr = {w_cur, r_lvl};
                    n_state      = S_CHARGE;
                end else if (w_cur == r_tail[r_lvl]) begin
                    n_use_link = 1'b0;
                    if (r_lvl == '0) begin
                        n_status = ST_IDLE;
                        n_state  = S_DONE;
                    end else begin
                        n_lvl   = w_lvl_down;
                        n_state = S_SCAN_LVL;
                    end
                end else begin
                    w_link_raddr = w_cur;
                    n_use_link   = 1'b1;
                end
            end

            S_CHARGE: begin
                w_tick_we    = 1'b1;
                w_tick_waddr = {r_cur, r_lvl};
                w_tick_wdata = w_alu_count;
                n_ticks      = w_alu_count;
                n_granted    = 1'b1;
                n_dem        = w_alu_demote;
                if (w_alu_demote) begin
                    n_unl   = r_cur;
                    n_state = S_UNL_RD;
                end else begin
                    n_state = S_DONE;
                end
            end

            // demoted slot joins the tail of the next lower queue
            S_APPEND: begin
                w_lvl_we    = 1'b1;
                w_lvl_waddr = r_cur;
                w_lvl_wdata = w_lvl_down;
                if (r_nonempty[w_lvl_down]) begin
                    w_link_we    = 1'b1;
                    w_link_waddr = r_tail[w_lvl_down];
                    w_link_wdata = r_cur;
                end else begin
                    n_head[w_lvl_down]     = r_cur;
                    n_nonempty[w_lvl_down] = 1'b1;
                end
                n_tail[w_lvl_down] = r_cur;
                n_state            = S_DONE;
            end

            S_DONE: begin
                o_done = 1'b1;
                if (i_take) n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase

        // unlink finished: release clears the slot, demotion goes on to append
        if (w_unl_done) begin
            if (r_action == ACT_RELEASE) begin
                n_in_use[r_unl] = 1'b0;
                n_ready[r_unl]  = 1'b0;
                n_state         = S_DONE;
            end else begin
                n_state = S_APPEND;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_use   <= '0;
            r_ready    <= '0;
            r_nonempty <= '0;
            for (int i = 0; i < LEVEL_DEPTH; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_in_use   <= n_in_use;
            r_ready    <= n_ready;
            r_nonempty <= n_nonempty;
            r_head     <= n_head;
            r_tail     <= n_tail;
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_slot     <= n_slot;
        r_slot_ok  <= n_slot_ok;
        r_rdy_req  <= n_rdy_req;
        r_status   <= n_status;
        r_granted  <= n_granted;
        r_dem      <= n_dem;
        r_ticks    <= n_ticks;
        r_lvl      <= n_lvl;
        r_cur      <= n_cur;
        r_use_link <= n_use_link;
        r_unl      <= n_unl;
        r_next_s   <= n_next_s;
        r_prev     <= n_prev;
        r_clr      <= n_clr;
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (w_link_we) r_link_mem[w_link_waddr] <= w_link_wdata;
        r_link_rdata <= r_link_mem[w_link_raddr];
    end

    // slot level memory
    always_ff @(posedge i_clk) begin
        if (w_lvl_we) r_level_mem[w_lvl_waddr] <= w_lvl_wdata;
        if (w_lvl_re) r_ulvl <= r_level_mem[w_lvl_raddr];
    end

    // tick count memory
    always_ff @(posedge i_clk) begin
        if (w_tick_we) r_tick_mem[w_tick_waddr] <= w_tick_wdata;
        if (w_tick_re) r_tick_rdata <= r_tick_mem[w_tick_raddr];
    end

    // result word
    always_comb begin
        o_result.granted = r_granted;
        o_result.slot    = r_granted ? SLOT_IW'(r_cur) : '0;
        o_result.level   = r_granted ? LEVEL_OW'(r_lvl) : '0;
        o_result.demoted = r_dem;
        o_result.ticks   = r_granted ? TICKS_OW'(r_ticks) : '0;
        o_result.status  = r_status;
    end

    `MFQS_ASSERT_IMP(a_ready_in_use, 1'b1, (r_ready & ~r_in_use) == '0, "ready flag on free slot")
    `MFQS_ASSERT_IMP(a_append_level, r_state == S_APPEND, r_lvl != '0, "demotion below level zero")
    `MFQS_ASSERT_NEXT(a_accept_decode, r_state == S_IDLE && i_valid, r_state == S_DECODE, "word not decoded")
    `MFQS_ASSERT_IMP(a_grant_live, o_done && r_granted, r_status == ST_OK && r_in_use[r_cur] && r_ready[r_cur], "grant of idle slot")

endmodule

/* design/multilevel_feedback_queue_scheduler_core.sv */
// ============================================================================
// multilevel_feedback_queue_scheduler_core
// Four-level feedback queue scheduler over a table of task slots.
//
//  Channel  | Dir | Signals                                         | Handshake
//  ---------+-----+-------------------------------------------------+-----------
//  in       | in  | i_action i_slot_index i_ready_req               | valid/ready
//  out      | out | o_granted o_granted_slot o_granted_level        | valid/ready
//           |     | o_demoted o_ticks_used o_status                 |
//  cfg      | in  | psel penable pwrite paddr pwdata prdata pready  | APB
//
//  One word is in work at a time; o_in_ready is high only when the sequencer is idle.
//  Admit: tick-count clear, one level per cycle.
//  Set ready / bad request: decode, then done. Release: unlink read, head check, queue walk.
//  Tick: levels visited in turn and queue entries scanned one by one, through the
//  single link memory read port; a demotion adds the unlink walk and the append.
//  Synchronous active-low reset; all queues empty, all slots free, no clearing pass.
//  A finished word waits in the output register while the next word is accepted.
// ============================================================================
module multilevel_feedback_queue_scheduler_core
    import mfqs_pkg::*;
#(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int NUM_LEVELS = DEF_NUM_LEVELS,
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_action,
    input  logic [SLOT_IW-1:0]  i_slot_index,
    input  logic                i_ready_req,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_granted,
    output logic [SLOT_IW-1:0]  o_granted_slot,
    output logic [LEVEL_OW-1:0] o_granted_level,
    output logic                o_demoted,
    output logic [TICKS_OW-1:0] o_ticks_used,
    output logic [1:0]          o_status,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready
);

    t_limits w_limits;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_done;
    logic    w_take;

    mfqs_cfg_regs u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (w_limits)
    );

    mfqs_engine #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_LEVELS (NUM_LEVELS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_limits     (w_limits),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_action     (i_action),
        .i_slot_index (i_slot_index),
        .i_ready_req  (i_ready_req),
        .o_done       (w_done),
        .i_take       (w_take),
        .o_result     (w_result)
    );

    // output register: load when empty or being drained
    assign w_take = w_done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_out <= w_result;
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted       = r_out.granted;
    assign o_granted_slot  = r_out.slot;
    assign o_granted_level = r_out.level;
    assign o_demoted       = r_out.demoted;
    assign o_ticks_used    = r_out.ticks;
    assign o_status        = r_out.status;

endmodule
